/* hdl/grid_cell_locate_and_weights_assert.svh */
// assertion macros used by the checker file
`ifndef GRID_CELL_LOCATE_AND_WEIGHTS_ASSERT_SVH
`define GRID_CELL_LOCATE_AND_WEIGHTS_ASSERT_SVH

// property that holds on every clock edge outside reset
`define GCLW_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// implication whose consequent is checked in the cycle after the antecedent
`define GCLW_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/gclw_pkg.sv */
package gclw_pkg;

  localparam int unsigned MaxDims     = 4;
  localparam int unsigned MaxPoints   = 64;
  localparam int unsigned CoordBits   = 32;
  localparam int unsigned FracBits    = 16;
  localparam int unsigned IdxBits     = $clog2(MaxPoints);
  localparam int unsigned DimBits     = $clog2(MaxDims);
  localparam int unsigned AddrBits    = IdxBits + DimBits;
  localparam int unsigned WeightBits  = FracBits + 1;
  localparam int unsigned CntBits     = IdxBits + 1;
  localparam int unsigned NumBits     = CoordBits + 1;
  localparam int unsigned DividendBits = NumBits + FracBits;

  // input item: tdata bit layout (mode in tuser)
  localparam int unsigned InDataBits  = 2 + 6 + 32 * 5;
  // output item tdata: status, corner, weight, 4 base indices
  localparam int unsigned OutDataBits = 48;

  // register indexes
  localparam logic [2:0] RegDims = 3'd0;
  localparam logic [2:0] RegPts0 = 3'd1;
  localparam logic [2:0] RegPts3 = 3'd4;

  localparam logic ModeLoad  = 1'b0;
  localparam logic ModeQuery = 1'b1;

  // request to the divider
  typedef struct packed {
    logic                    start;
    logic [DividendBits-1:0] num;
    logic [NumBits-1:0]      den;
  } div_req_t;

  typedef struct packed {
    logic                done;
    logic [WeightBits-1:0] weight;
  } div_rsp_t;

endpackage

/* hdl/gclw_div.sv */
// restoring divider, one quotient bit per cycle, saturated to one
module gclw_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  gclw_pkg::div_req_t req_i,
  output gclw_pkg::div_rsp_t rsp_o
);
  localparam int unsigned DB = gclw_pkg::DividendBits;
  localparam int unsigned NB = gclw_pkg::NumBits;

  logic [DB-1:0] quo_q, quo_d;
  logic [NB:0]   rem_q, rem_d;
  logic [NB-1:0] den_q, den_d;
  logic [$clog2(DB+1)-1:0] cnt_q, cnt_d;
  logic busy_q, busy_d, done_q, done_d;
  logic [NB:0] trial;

  // one step of the shift and subtract
  always_comb begin
    quo_d = quo_q; rem_d = rem_q; den_d = den_q; cnt_d = cnt_q;
    busy_d = busy_q; done_d = 1'b0;
    trial = {rem_q[NB-1:0], quo_q[DB-1]};
    if (req_i.start) begin
      quo_d = req_i.num; rem_d = '0; den_d = req_i.den;
      cnt_d = ($clog2(DB+1))'(DB); busy_d = 1'b1;
    end else if (busy_q) begin
      quo_d = {quo_q[DB-2:0], 1'b0};
      if (trial >= {1'b0, den_q}) begin
        rem_d = trial - {1'b0, den_q};
        quo_d[0] = 1'b1;
      end else begin
        rem_d = trial;
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == ($clog2(DB+1))'(1)) begin
        busy_d = 1'b0; done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; done_q <= 1'b0; cnt_q <= '0;
    end else begin
      busy_q <= busy_d; done_q <= done_d; cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d; rem_q <= rem_d; den_q <= den_d;
  end

  // saturate at one
  always_comb begin
    rsp_o.done = done_q;
    if (quo_q > DB'(1 << gclw_pkg::FracBits))
      rsp_o.weight = gclw_pkg::WeightBits'(1 << gclw_pkg::FracBits);
    else
      rsp_o.weight = quo_q[gclw_pkg::WeightBits-1:0];
  end
endmodule

/* hdl/grid_cell_locate_and_weights.sv */
// channel   dir  payload (low bit first)
// s_axis    in   tdata: load_dim, load_index, load_value, coord_0..3; tuser: mode
// m_axis    out  tdata: status, corner, corner_weight, base_index_0..3; tlast: last
// cfg       in   cfg_we_i, cfg_idx_i, cfg_data_i
// a load is written in its accept cycle; a query reads the end points of each dimension,
// scans its grid points one at a time and runs the serial divide, then for each corner
// it multiplies in one factor per dimension (StCorn, StMul, StOut); one item at a time
// reset clears control and sets the configuration registers to two dimensions of two points;
// table contents are undefined until loaded; a stalled result holds in the output register and blocks the next item
module grid_cell_locate_and_weights (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [167:0] s_axis_tdata,  // load_dim, load_index, load_value, coord_0..3
  input  logic         s_axis_tuser,  // mode
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [47:0]  m_axis_tdata,  // status, corner, corner_weight, base_index_0..3
  output logic         m_axis_tlast,  // last
  input  logic         cfg_we_i,
  input  logic [2:0]   cfg_idx_i,
  input  logic [6:0]   cfg_data_i
);
  localparam int unsigned CB = gclw_pkg::CoordBits;
  localparam int unsigned IB = gclw_pkg::IdxBits;
  localparam int unsigned FB = gclw_pkg::FracBits;
  localparam int unsigned WB = gclw_pkg::WeightBits;
  localparam int unsigned NB = gclw_pkg::NumBits;

  typedef enum logic [7:0] {
    StIdle  = 8'b0000_0001,
    StFirst = 8'b0000_0010,
    StLastP = 8'b0000_0100,
    StScan  = 8'b0000_1000,
    StDiv   = 8'b0001_0000,
    StCorn  = 8'b0010_0000,
    StMul   = 8'b0100_0000,
    StOut   = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  // configuration
  logic [2:0] dims_q;
  logic [6:0] pts_q [gclw_pkg::MaxDims];
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dims_q <= 3'd2;
      for (int i = 0; i < gclw_pkg::MaxDims; i++) pts_q[i] <= 7'd2;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == gclw_pkg::RegDims) dims_q <= cfg_data_i[2:0];
      else if (cfg_idx_i >= gclw_pkg::RegPts0 && cfg_idx_i <= gclw_pkg::RegPts3)
        pts_q[2'(cfg_idx_i - gclw_pkg::RegPts0)] <= cfg_data_i;
    end
  end

  // clamped settings
  logic [2:0] nd;
  logic [6:0] npts;
  logic [1:0] dim_q;
  always_comb begin
    nd = (dims_q == 3'd0) ? 3'd1 : (dims_q > 3'd4) ? 3'd4 : dims_q;
    npts = pts_q[dim_q];
    if (npts < 7'd2) npts = 7'd2;
    else if (npts > 7'(gclw_pkg::MaxPoints)) npts = 7'(gclw_pkg::MaxPoints);
  end

  // coordinate table, one port, registered read
  logic [CB-1:0] mem [gclw_pkg::MaxDims * gclw_pkg::MaxPoints];
  logic          mem_we;
  logic [gclw_pkg::AddrBits-1:0] mem_addr;
  logic [CB-1:0] mem_wdata, rdata_q;
  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_addr] <= mem_wdata;
    rdata_q <= mem[mem_addr];
  end

  // captured item
  logic [CB-1:0] pt_q [gclw_pkg::MaxDims];
  logic [IB-1:0] idx_q, idx_d;
  logic [IB-1:0] base_q [gclw_pkg::MaxDims];
  logic [WB-1:0] w_q [gclw_pkg::MaxDims];
  logic signed [CB-1:0] c0_q, prev_q;
  logic [3:0] corner_q;
  logic [1:0] md_q;
  logic [WB-1:0] acc_q;
  logic [2*WB-1:0] prod;
  logic [47:0] out_data_q;
  logic out_last_q, out_valid_q;

  logic accept;
  assign accept = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == StIdle) && !out_valid_q;

  logic signed [CB-1:0] p, cur;
  assign p   = pt_q[dim_q];
  assign cur = rdata_q;

  gclw_pkg::div_req_t dreq;
  gclw_pkg::div_rsp_t drsp;
  gclw_div u_div (.clk_i, .rst_ni, .req_i(dreq), .rsp_o(drsp));

  logic signed [NB-1:0] num_s, den_s;
  assign num_s = NB'(p) - NB'(prev_q);
  assign den_s = NB'(cur) - NB'(prev_q);

  logic [WB-1:0] fac;
  assign fac = corner_q[md_q] ? w_q[md_q] : WB'(1 << FB) - w_q[md_q];

  // running corner product, full width before the shift
  assign prod = {{WB{1'b0}}, acc_q} * {{WB{1'b0}}, fac};

  logic oor_go, out_go, dec;
  always_comb begin
    state_d = state_q; idx_d = idx_q;
    mem_we = 1'b0; mem_wdata = s_axis_tdata[39:8];
    mem_addr = {dim_q, idx_q};
    dreq = '0; oor_go = 1'b0; out_go = 1'b0; dec = 1'b0;
    unique case (state_q)
      StIdle: begin
        if (accept) begin
          if (s_axis_tuser == gclw_pkg::ModeLoad) begin
            mem_we = 1'b1; mem_addr = {s_axis_tdata[1:0], s_axis_tdata[7:2]};
          end else begin
            mem_addr = '0; idx_d = '0; state_d = StFirst;
          end
        end
      end
      // c[0] in rdata, request c[n-1]
      StFirst: begin
        mem_addr = {dim_q, IB'(npts - 7'd1)};
        state_d = StLastP;
      end
      StLastP: begin
        if (p < c0_q || p > cur) begin
          oor_go = 1'b1; state_d = StOut;
        end else begin
          idx_d = IB'(1); mem_addr = {dim_q, IB'(1)}; state_d = StScan;
        end
      end
      // rdata holds c[idx_q] in the cycle after its address
      StScan: begin
        if (p <= cur) begin
          dreq.start = 1'b1;
          dreq.num = {num_s, FB'(0)};
          dreq.den = den_s;
          state_d = StDiv;
        end else begin
          idx_d = idx_q + 1'b1; mem_addr = {dim_q, IB'(idx_q + 1'b1)};
        end
      end
      StDiv: begin
        if (drsp.done) begin
          if (2'(dim_q) == 2'(nd - 3'd1)) state_d = StCorn;
          else begin
            mem_addr = {dim_q + 1'b1, IB'(0)}; idx_d = '0; state_d = StFirst;
          end
        end
      end
      StCorn: state_d = StMul;
      StMul: begin
        if ({1'b0, md_q} == nd - 3'd1) begin
          out_go = 1'b1; state_d = StOut;
        end
      end
      StOut: begin
        if (!out_valid_q) begin
          if (out_last_q) state_d = StIdle;
          else state_d = StCorn;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // interval sign checks; prev_q and the read word hold through the divide
  logic den_pos, num_pos;
  assign den_pos = !den_s[NB-1] && den_s != '0;
  assign num_pos = !num_s[NB-1] && num_s != '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle; out_valid_q <= 1'b0; out_last_q <= 1'b0;
      dim_q <= '0; idx_q <= '0;
    end else begin
      state_q <= state_d; idx_q <= idx_d;
      if (oor_go || out_go) out_valid_q <= 1'b1;
      else if (m_axis_tready) out_valid_q <= 1'b0;
      if (oor_go) out_last_q <= 1'b1;
      else if (out_go) out_last_q <= ({1'b0, corner_q} == (5'd1 << nd) - 5'd1);
      if (accept) dim_q <= '0;
      else if (state_q == StDiv && drsp.done && state_d == StFirst) dim_q <= dim_q + 1'b1;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      for (int i = 0; i < gclw_pkg::MaxDims; i++) begin
        pt_q[i] <= s_axis_tdata[40 + 32*i +: 32];
        base_q[i] <= '0;
        w_q[i] <= '0;
      end
      corner_q <= '0;
    end
    if (state_q == StFirst) c0_q <= cur;
    if (state_q == StLastP) prev_q <= c0_q;
    if (state_q == StScan && !(p <= cur)) prev_q <= cur;
    if (state_q == StScan && p <= cur) begin
      base_q[dim_q] <= IB'(idx_q - 1'b1);
      if (!(den_pos && num_pos)) w_q[dim_q] <= '0;
    end
    if (state_q == StDiv && drsp.done && den_pos && num_pos) w_q[dim_q] <= drsp.weight;
    if (state_q == StCorn) begin
      md_q <= '0; acc_q <= WB'(1 << FB);
    end
    if (state_q == StMul) begin
      acc_q <= prod[FB +: WB];
      md_q <= md_q + 1'b1;
    end
    if (state_q == StOut && !out_valid_q && !out_last_q) corner_q <= corner_q + 1'b1;
    if (oor_go) out_data_q <= 48'h1;
    if (out_go)
      out_data_q <= {2'b00, base_q[3], base_q[2], base_q[1], base_q[0],
                     prod[FB +: WB], corner_q, 1'b0};
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;
endmodule

/* hdl/gclw_checker.sv */
module gclw_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [47:0] m_axis_tdata,
  input logic        m_axis_tlast
);
`include "grid_cell_locate_and_weights_assert.svh"

  `GCLW_ASSERT_NEXT(a_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result changed while stalled")
  `GCLW_ASSERT(a_oor_last, !(m_axis_tvalid && m_axis_tdata[0]) || m_axis_tlast, "out of range result not last")
  `GCLW_ASSERT(a_wmax, !m_axis_tvalid || m_axis_tdata[21:5] <= 17'd65536, "weight above one")
  `GCLW_ASSERT(a_busy, !(m_axis_tvalid && s_axis_tready), "input taken while result pending")
endmodule

bind grid_cell_locate_and_weights gclw_checker u_chk (.*);
